// ----- hw/rtl/char_lcd_4bit_write_controller_core_macros.svh -----
// Assertion macros used by the file that checks the controller.
`ifndef CHAR_LCD_4BIT_WRITE_CONTROLLER_CORE_MACROS_SVH
`define CHAR_LCD_4BIT_WRITE_CONTROLLER_CORE_MACROS_SVH

// Checked at every rising edge outside reset.
`define CLCD4_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CLCD4_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ----- hw/rtl/clcd4_pkg.sv -----
`timescale 1ns / 1ps

package clcd4_pkg;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_CMD  = 2'd1,
        OP_DATA = 2'd2,
        OP_INIT = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_POWER_ON_WAIT   = 3'd0,
        CFG_FIRST_WAKE_WAIT = 3'd1,
        CFG_ENABLE_PHASE    = 3'd2,
        CFG_USE_BUSY_POLL   = 3'd3,
        CFG_FIXED_WAIT      = 3'd4
    } t_cfg_idx;

    typedef enum logic [4:0] {
        PH_UNINIT    = 5'd0,
        PH_POWER     = 5'd1,
        PH_NIB_SET   = 5'd2,
        PH_NIB_HIGH  = 5'd3,
        PH_WAKE_WAIT = 5'd4,
        PH_HI_SET    = 5'd5,
        PH_HI_HIGH   = 5'd6,
        PH_LO_SET    = 5'd7,
        PH_LO_HIGH   = 5'd8,
        PH_BS1       = 5'd9,
        PH_BH1       = 5'd10,
        PH_BS2       = 5'd11,
        PH_BS2_BUSY  = 5'd12,
        PH_BH2       = 5'd13,
        PH_BH2_BUSY  = 5'd14,
        PH_BUSY_GAP  = 5'd15,
        PH_FIXED     = 5'd16,
        PH_READY     = 5'd17
    } t_phase;

    localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
    localparam logic [7:0] CMD_DISPLAY_OFF  = 8'h08;
    localparam logic [7:0] CMD_CLEAR        = 8'h01;
    localparam logic [7:0] CMD_DISPLAY_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY_MODE   = 8'h06;

    localparam logic [3:0] NIB_WAKE         = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT     = 4'h2;

    localparam logic [3:0] STEP_FIRST_CMD   = 4'd3;
    localparam logic [3:0] STEP_LAST_CMD    = 4'd7;
    localparam logic [3:0] STEP_DONE        = 4'd9;

    localparam logic [7:0] RST_POWER_ON_WAIT   = 8'd40;
    localparam logic [7:0] RST_FIRST_WAKE_WAIT = 8'd5;
    localparam logic [3:0] RST_ENABLE_PHASE    = 4'd1;
    localparam logic       RST_USE_BUSY_POLL   = 1'b1;
    localparam logic [7:0] RST_FIXED_WAIT      = 8'd2;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic       busy_pin;
    } t_in;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_rw;
        logic       pin_e;
        logic [3:0] pin_nibble;
        logic       db7_as_input;
        logic       ready_res;
        logic       refused;
    } t_out;

    typedef struct packed {
        logic [7:0] power_on_wait_ms;
        logic [7:0] first_wake_wait_ms;
        logic [3:0] enable_phase_ms;
        logic       use_busy_poll;
        logic [7:0] fixed_wait_ms;
    } t_cfg;

    typedef struct packed {
        logic       din;
        logic [3:0] nib;
        logic       e;
        logic       rw;
        logic       rs;
    } t_pins;

    // DB7 reads as low whenever it is released.
    function automatic t_pins f_drive(input logic rs, input logic rw, input logic e,
                                      input logic [3:0] nib, input logic din);
        t_pins p;
        p.rs  = rs;
        p.rw  = rw;
        p.e   = e;
        p.nib = din ? {1'b0, nib[2:0]} : nib;
        p.din = din;
        return p;
    endfunction

    function automatic logic [7:0] f_setup_cmd(input logic [3:0] step);
        logic [7:0] c;
        case (step)
            4'd4:    c = CMD_FUNCTION_SET;
            4'd5:    c = CMD_DISPLAY_OFF;
            4'd6:    c = CMD_CLEAR;
            4'd7:    c = CMD_DISPLAY_ON;
            4'd8:    c = CMD_ENTRY_MODE;
            default: c = CMD_FUNCTION_SET;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/clcd4_cfg.sv -----
`timescale 1ns / 1ps

module clcd4_cfg
    import clcd4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POWER_ON_WAIT:   n_cfg.power_on_wait_ms   = i_cfg_wdata;
                CFG_FIRST_WAKE_WAIT: n_cfg.first_wake_wait_ms = i_cfg_wdata;
                CFG_ENABLE_PHASE:    n_cfg.enable_phase_ms    = i_cfg_wdata[3:0];
                CFG_USE_BUSY_POLL:   n_cfg.use_busy_poll      = i_cfg_wdata[0];
                CFG_FIXED_WAIT:      n_cfg.fixed_wait_ms      = i_cfg_wdata;
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_on_wait_ms   <= RST_POWER_ON_WAIT;
            r_cfg.first_wake_wait_ms <= RST_FIRST_WAKE_WAIT;
            r_cfg.enable_phase_ms    <= RST_ENABLE_PHASE;
            r_cfg.use_busy_poll      <= RST_USE_BUSY_POLL;
            r_cfg.fixed_wait_ms      <= RST_FIXED_WAIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- hw/rtl/clcd4_seq.sv -----
`timescale 1ns / 1ps

module clcd4_seq
    import clcd4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_in,
    input  t_cfg i_cfg,
    output t_out o_res
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_ms, n_ms;
    logic [7:0] r_byte, n_byte;
    logic       r_rs_held, n_rs_held;
    logic [3:0] r_step, n_step;
    t_pins      r_pins, n_pins;

    logic [8:0] ms_inc;
    logic [7:0] target;
    logic       done;
    logic       refused;
    logic       do_after;
    logic       do_cont;
    logic [7:0] cmd;

    always_comb begin
        case (r_phase)
            PH_POWER:     target = i_cfg.power_on_wait_ms;
            PH_WAKE_WAIT: target = (r_step == 4'd0) ? i_cfg.first_wake_wait_ms : 8'd1;
            PH_BUSY_GAP:  target = 8'd1;
            PH_FIXED:     target = i_cfg.fixed_wait_ms;
            default:      target = {4'd0, i_cfg.enable_phase_ms};
        endcase
        ms_inc = {1'b0, r_ms} + 9'd1;
        done   = (ms_inc >= {1'b0, target});
    end

    always_comb begin
        n_phase   = r_phase;
        n_ms      = r_ms;
        n_byte    = r_byte;
        n_rs_held = r_rs_held;
        n_step    = r_step;
        n_pins    = r_pins;
        refused   = 1'b0;
        do_after  = 1'b0;
        do_cont   = 1'b0;
        cmd       = f_setup_cmd(4'(r_step + 4'd1));

        case (t_op'(i_in.opcode))
            OP_TICK: begin
                if (r_phase != PH_UNINIT && r_phase != PH_READY) begin
                    n_ms = done ? 8'd0 : ms_inc[7:0];
                    if (done) begin
                        case (r_phase)
                            PH_POWER: begin
                                n_pins  = f_drive(1'b0, 1'b0, 1'b0, NIB_WAKE, 1'b0);
                                n_phase = PH_NIB_SET;
                            end
                            PH_NIB_SET: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_NIB_HIGH;
                            end
                            PH_NIB_HIGH: begin
                                n_pins.e = 1'b0;
                                if (r_step >= STEP_FIRST_CMD) begin
                                    do_after = 1'b1;
                                end else begin
                                    n_phase = PH_WAKE_WAIT;
                                end
                            end
                            PH_WAKE_WAIT: begin
                                n_step = 4'(r_step + 4'd1);
                                n_pins = f_drive(r_pins.rs, r_pins.rw, r_pins.e,
                                                 (n_step == 4'd3) ? NIB_FOUR_BIT : NIB_WAKE,
                                                 r_pins.din);
                                n_phase = PH_NIB_SET;
                            end
                            PH_HI_SET: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_HI_HIGH;
                            end
                            PH_HI_HIGH: begin
                                n_pins = f_drive(r_pins.rs, r_pins.rw, 1'b0, r_byte[3:0],
                                                 r_pins.din);
                                n_phase = PH_LO_SET;
                            end
                            PH_LO_SET: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_LO_HIGH;
                            end
                            PH_LO_HIGH: begin
                                n_pins.e = 1'b0;
                                do_after = 1'b1;
                            end
                            PH_BS1: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_BH1;
                            end
                            PH_BH1: begin
                                n_pins.e = 1'b0;
                                n_phase  = i_in.busy_pin ? PH_BS2_BUSY : PH_BS2;
                            end
                            PH_BS2: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_BH2;
                            end
                            PH_BS2_BUSY: begin
                                n_pins.e = 1'b1;
                                n_phase  = PH_BH2_BUSY;
                            end
                            PH_BH2: begin
                                n_pins  = f_drive(1'b0, 1'b0, 1'b0, {1'b0, r_pins.nib[2:0]},
                                                  1'b0);
                                do_cont = 1'b1;
                            end
                            PH_BH2_BUSY: begin
                                n_pins.e = 1'b0;
                                n_phase  = PH_BUSY_GAP;
                            end
                            PH_BUSY_GAP: begin
                                n_phase = PH_BS1;
                            end
                            PH_FIXED: begin
                                do_cont = 1'b1;
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
            OP_INIT: begin
                if (r_phase == PH_UNINIT || r_phase == PH_READY) begin
                    n_pins  = f_drive(1'b0, 1'b0, 1'b0, r_pins.nib, 1'b0);
                    n_ms    = 8'd0;
                    n_step  = 4'd0;
                    n_phase = PH_POWER;
                end else begin
                    refused = 1'b1;
                end
            end
            default: begin
                if (r_phase == PH_READY) begin
                    n_byte    = i_in.data_byte;
                    n_rs_held = (t_op'(i_in.opcode) == OP_DATA);
                    n_pins    = f_drive(n_rs_held, 1'b0, 1'b0, i_in.data_byte[7:4], 1'b0);
                    n_ms      = 8'd0;
                    n_phase   = PH_HI_SET;
                end else begin
                    refused = 1'b1;
                end
            end
        endcase

        if (do_after) begin
            n_ms = 8'd0;
            if (i_cfg.use_busy_poll) begin
                n_pins  = f_drive(1'b0, 1'b1, 1'b0, n_pins.nib, 1'b1);
                n_phase = PH_BS1;
            end else begin
                n_phase = PH_FIXED;
            end
        end

        if (do_cont) begin
            if (r_step inside {[STEP_FIRST_CMD:STEP_LAST_CMD]}) begin
                n_step    = 4'(r_step + 4'd1);
                n_byte    = cmd;
                n_rs_held = 1'b0;
                n_pins    = f_drive(1'b0, 1'b0, 1'b0, cmd[7:4], 1'b0);
                n_ms      = 8'd0;
                n_phase   = PH_HI_SET;
            end else begin
                n_step  = STEP_DONE;
                n_phase = PH_READY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_UNINIT;
            r_ms      <= 8'd0;
            r_byte    <= 8'd0;
            r_rs_held <= 1'b0;
            r_step    <= 4'd0;
            r_pins    <= '0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_ms      <= n_ms;
            r_byte    <= n_byte;
            r_rs_held <= n_rs_held;
            r_step    <= n_step;
            r_pins    <= n_pins;
        end
    end

    assign o_res.pin_rs       = n_pins.rs;
    assign o_res.pin_rw       = n_pins.rw;
    assign o_res.pin_e        = n_pins.e;
    assign o_res.pin_nibble   = n_pins.nib;
    assign o_res.db7_as_input = n_pins.din;
    assign o_res.ready_res    = (n_phase == PH_READY);
    assign o_res.refused      = refused;

endmodule

// ----- hw/rtl/clcd4_out.sv -----
`timescale 1ns / 1ps

module clcd4_out
    import clcd4_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_out i_res,
    input  logic i_out_stall,
    output logic o_in_stall,
    output logic o_out_valid,
    output t_out o_out
);

    logic r_valid, n_valid;
    t_out r_data;

    assign o_in_stall = r_valid && i_out_stall;

    always_comb begin
        n_valid = r_valid;
        if (i_accept) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_data;

endmodule

// ----- hw/rtl/char_lcd_4bit_write_controller_core.sv -----
// The result of a request is registered and shown in the cycle after the request is taken.
// Throughput: one request per cycle while the output is not stalled, set by the single
// result register, which frees itself in the same cycle that its result is taken.
// Reset (synchronous, active low) restores the register defaults, leaves the
// display uninitialised with all pins low and empties the result register.
`timescale 1ns / 1ps

`include "char_lcd_4bit_write_controller_core_macros.svh"

module char_lcd_4bit_write_controller_core
    import clcd4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out
);

    t_cfg cfg;
    t_out res;
    logic accept;

    assign accept = i_in_valid && !o_in_stall;

    clcd4_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    clcd4_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .i_cfg    (cfg),
        .o_res    (res)
    );

    clcd4_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    `CLCD4_ASSERT(a_ready_pins_idle, o_out_valid && o_out.ready_res |-> !o_out.pin_e && !o_out.pin_rw && !o_out.db7_as_input, "ready with bus not idle")
    `CLCD4_ASSERT(a_db7_released_low, o_out_valid && o_out.db7_as_input |-> !o_out.pin_nibble[3], "released DB7 driven high")
    `CLCD4_ASSERT(a_tick_not_refused, accept && i_in.opcode == OP_TICK |=> o_out_valid && !o_out.refused, "tick refused")
    `CLCD4_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import clcd4_pkg::*;

    typedef struct packed {
        t_phase     ph;
        logic [7:0] ms;
        logic [7:0] byte_q;
        logic       rs_q;
        logic [3:0] step;
        t_pins      pins;
    } t_lcd_state;

    localparam logic [4:0][7:0] SETUP_SEQ = {CMD_ENTRY_MODE, CMD_DISPLAY_ON, CMD_CLEAR,
                                             CMD_DISPLAY_OFF, CMD_FUNCTION_SET};
    localparam logic [2:0] CFG_IDX_SPARE = 3'd7;
    localparam int HOLD_A_START = 150;
    localparam int HOLD_B_START = 1500;
    localparam int HOLD_LEN = 100;
    localparam int TIMEOUT_NS = 2_000_000;

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [2:0] cfg_idx = '0;
    logic [7:0] cfg_wdata = '0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    t_in        in_req = '0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    t_out       out_res;

    t_cfg       lcd_cfg;
    t_lcd_state lcd_now;
    t_lcd_state lcd_plan;
    t_in        request_q[$];
    t_out       pin_levels_q[$];
    t_out       want;
    int         mismatch_cnt = 0;
    int         burst_left = 1;
    int         gap_left = 0;
    int         stall_mode = 0;
    int         stall_left = 0;
    int         cycle_cnt = 0;
    logic       hold_off = 1'b0;

    char_lcd_4bit_write_controller_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_res)
    );

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic t_pins pins_of(input logic rs, input logic rw, input logic e,
                                      input logic [3:0] nib, input logic din);
        t_pins p;
        p.rs  = rs;
        p.rw  = rw;
        p.e   = e;
        p.din = din;
        p.nib = nib;
        if (din) begin
            p.nib[3] = 1'b0;
        end
        return p;
    endfunction

    function automatic bit wait_done(inout t_lcd_state s, input logic [8:0] target);
        logic [8:0] c;
        c = {1'b0, s.ms} + 9'd1;
        if (c >= target) begin
            s.ms = '0;
            return 1'b1;
        end
        s.ms = c[7:0];
        return 1'b0;
    endfunction

    function automatic void load_byte(inout t_lcd_state s, input logic [7:0] b,
                                      input logic rs);
        s.byte_q = b;
        s.rs_q   = rs;
        s.pins   = pins_of(rs, 1'b0, 1'b0, b[7:4], 1'b0);
        s.ms     = '0;
        s.ph     = PH_HI_SET;
    endfunction

    function automatic void byte_sent(inout t_lcd_state s);
        s.ms = '0;
        if (lcd_cfg.use_busy_poll) begin
            s.pins = pins_of(1'b0, 1'b1, 1'b0, s.pins.nib, 1'b1);
            s.ph   = PH_BS1;
        end else begin
            s.ph = PH_FIXED;
        end
    endfunction

    function automatic void next_after_wait(inout t_lcd_state s);
        if (s.step >= STEP_FIRST_CMD && s.step <= STEP_LAST_CMD) begin
            s.step++;
            load_byte(s, SETUP_SEQ[3'(s.step - STEP_FIRST_CMD - 4'd1)], 1'b0);
        end else begin
            s.step = STEP_DONE;
            s.ph   = PH_READY;
        end
    endfunction

    // Advances the controller by one request and returns the pin levels that follow it.
    function automatic t_out lcd_pins_after(inout t_lcd_state s, input t_in it);
        t_out       r;
        logic       refused;
        logic [8:0] en;
        refused = 1'b0;
        en = {5'd0, lcd_cfg.enable_phase_ms};
        case (t_op'(it.opcode))
            OP_TICK: begin
                case (s.ph)
                    PH_POWER: if (wait_done(s, {1'b0, lcd_cfg.power_on_wait_ms})) begin
                        s.pins = pins_of(1'b0, 1'b0, 1'b0, NIB_WAKE, 1'b0);
                        s.ph = PH_NIB_SET;
                    end
                    PH_NIB_SET: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_NIB_HIGH;
                    end
                    PH_NIB_HIGH: if (wait_done(s, en)) begin
                        s.pins.e = 1'b0;
                        if (s.step >= STEP_FIRST_CMD) byte_sent(s);
                        else s.ph = PH_WAKE_WAIT;
                    end
                    PH_WAKE_WAIT: if (wait_done(s, (s.step == 4'd0) ?
                                                 {1'b0, lcd_cfg.first_wake_wait_ms} : 9'd1)) begin
                        s.step++;
                        s.pins.nib = (s.step == STEP_FIRST_CMD) ? NIB_FOUR_BIT : NIB_WAKE;
                        s.ph = PH_NIB_SET;
                    end
                    PH_HI_SET: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_HI_HIGH;
                    end
                    PH_HI_HIGH: if (wait_done(s, en)) begin
                        s.pins.e = 1'b0;
                        s.pins.nib = s.byte_q[3:0];
                        s.ph = PH_LO_SET;
                    end
                    PH_LO_SET: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_LO_HIGH;
                    end
                    PH_LO_HIGH: if (wait_done(s, en)) begin
                        s.pins.e = 1'b0;
                        byte_sent(s);
                    end
                    PH_BS1: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_BH1;
                    end
                    PH_BH1: if (wait_done(s, en)) begin
                        s.pins.e = 1'b0;
                        s.ph = it.busy_pin ? PH_BS2_BUSY : PH_BS2;
                    end
                    PH_BS2: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_BH2;
                    end
                    PH_BS2_BUSY: if (wait_done(s, en)) begin
                        s.pins.e = 1'b1;
                        s.ph = PH_BH2_BUSY;
                    end
                    PH_BH2: if (wait_done(s, en)) begin
                        s.pins = pins_of(1'b0, 1'b0, 1'b0, {1'b0, s.pins.nib[2:0]}, 1'b0);
                        next_after_wait(s);
                    end
                    PH_BH2_BUSY: if (wait_done(s, en)) begin
                        s.pins.e = 1'b0;
                        s.ph = PH_BUSY_GAP;
                    end
                    PH_BUSY_GAP: if (wait_done(s, 9'd1)) begin
                        s.ph = PH_BS1;
                    end
                    PH_FIXED: if (wait_done(s, {1'b0, lcd_cfg.fixed_wait_ms})) begin
                        next_after_wait(s);
                    end
                    default: ;
                endcase
            end
            OP_INIT: begin
                if (s.ph == PH_UNINIT || s.ph == PH_READY) begin
                    s.pins = pins_of(1'b0, 1'b0, 1'b0, s.pins.nib, 1'b0);
                    s.ms   = '0;
                    s.step = '0;
                    s.ph   = PH_POWER;
                end else begin
                    refused = 1'b1;
                end
            end
            default: begin
                if (s.ph == PH_READY) load_byte(s, it.data_byte, it.opcode == OP_DATA);
                else refused = 1'b1;
            end
        endcase
        r.pin_rs       = s.pins.rs;
        r.pin_rw       = s.pins.rw;
        r.pin_e        = s.pins.e;
        r.pin_nibble   = s.pins.nib;
        r.db7_as_input = s.pins.din;
        r.ready_res    = (s.ph == PH_READY);
        r.refused      = refused;
        return r;
    endfunction

    function automatic t_in make_req(input t_op op, input logic [7:0] b, input logic busy);
        t_in r;
        r.opcode    = op;
        r.data_byte = b;
        r.busy_pin  = busy;
        return r;
    endfunction

    function automatic t_in tick_req();
        logic busy;
        if (lcd_plan.ph == PH_BH1) busy = ($urandom_range(0, 2) == 0);
        else busy = 1'($urandom_range(0, 1));
        return make_req(OP_TICK, 8'($urandom_range(0, 255)), busy);
    endfunction

    function automatic t_in noise_req();
        return make_req(t_op'($urandom_range(1, 3)), 8'($urandom_range(0, 255)),
                        1'($urandom_range(0, 1)));
    endfunction

    function automatic void queue_req(input t_in it);
        void'(lcd_pins_after(lcd_plan, it));
        request_q.push_back(it);
    endfunction

    function automatic void queue_until_ready();
        while (lcd_plan.ph != PH_READY) begin
            queue_req(tick_req());
        end
    endfunction

    function automatic void queue_random(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (lcd_plan.ph == PH_READY) begin
                if (k < 40) queue_req(make_req(OP_CMD, 8'($urandom_range(0, 255)), 1'b0));
                else if (k < 75) queue_req(make_req(OP_DATA, 8'($urandom_range(0, 255)),
                                                    1'($urandom_range(0, 1))));
                else if (k < 85) queue_req(make_req(OP_INIT, 8'($urandom_range(0, 255)), 1'b0));
                else queue_req(tick_req());
            end else if (lcd_plan.ph == PH_UNINIT) begin
                if (k < 70) queue_req(make_req(OP_INIT, 8'($urandom_range(0, 255)), 1'b0));
                else queue_req(noise_req());
            end else begin
                if (k < 90) queue_req(tick_req());
                else queue_req(noise_req());
            end
        end
    endfunction

    task automatic wait_drain();
        do @(negedge clk);
        while (request_q.size() != 0 || pin_levels_q.size() != 0 || in_valid);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
        case (idx)
            CFG_POWER_ON_WAIT:   lcd_cfg.power_on_wait_ms   = val;
            CFG_FIRST_WAKE_WAIT: lcd_cfg.first_wake_wait_ms = val;
            CFG_ENABLE_PHASE:    lcd_cfg.enable_phase_ms    = val[3:0];
            CFG_USE_BUSY_POLL:   lcd_cfg.use_busy_poll      = val[0];
            CFG_FIXED_WAIT:      lcd_cfg.fixed_wait_ms      = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_setting(input logic [7:0] power, input logic [7:0] wake,
                               input logic [7:0] en, input logic [7:0] poll,
                               input logic [7:0] fixed, input int n);
        wait_drain();
        cfg_write(CFG_POWER_ON_WAIT, power);
        cfg_write(CFG_FIRST_WAKE_WAIT, wake);
        cfg_write(CFG_ENABLE_PHASE, en);
        cfg_write(CFG_USE_BUSY_POLL, poll);
        cfg_write(CFG_FIXED_WAIT, fixed);
        @(negedge clk);
        queue_random(n);
    endtask

    // Requests are presented in bursts; the predictor runs as each request is taken.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) pin_levels_q.push_back(lcd_pins_after(lcd_now, in_req));
            if (gap_left > 0 || request_q.size() == 0) begin
                in_valid <= 1'b0;
                if (gap_left > 0) gap_left--;
            end else begin
                in_valid <= 1'b1;
                in_req   <= request_q.pop_front();
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) cycle_cnt <= 0;
        else cycle_cnt <= cycle_cnt + 1;
        hold_off <= (cycle_cnt >= HOLD_A_START && cycle_cnt < HOLD_A_START + HOLD_LEN) ||
                    (cycle_cnt >= HOLD_B_START && cycle_cnt < HOLD_B_START + HOLD_LEN);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pin_levels_q.size() == 0) begin
                $display("%0t: result with no request outstanding: got %p", $time, out_res);
                mismatch_cnt++;
            end else begin
                want = pin_levels_q.pop_front();
                if (out_res !== want) begin
                    $display("%0t: mismatch: expected rs=%b rw=%b e=%b nib=%h din=%b rdy=%b ref=%b",
                             $time, want.pin_rs, want.pin_rw, want.pin_e, want.pin_nibble,
                             want.db7_as_input, want.ready_res, want.refused);
                    $display("%0t:           actual rs=%b rw=%b e=%b nib=%h din=%b rdy=%b ref=%b",
                             $time, out_res.pin_rs, out_res.pin_rw, out_res.pin_e,
                             out_res.pin_nibble, out_res.db7_as_input, out_res.ready_res,
                             out_res.refused);
                    mismatch_cnt++;
                end
            end
        end
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end else begin
            stall_left--;
        end
        out_stall <= hold_off || (stall_mode != 0 && $urandom_range(0, 3) < stall_mode);
    end

    initial begin
        #(TIMEOUT_NS);
        $display("char_lcd_4bit_write_controller_core test failed");
        $finish;
    end

    initial begin
        lcd_cfg.power_on_wait_ms   = RST_POWER_ON_WAIT;
        lcd_cfg.first_wake_wait_ms = RST_FIRST_WAKE_WAIT;
        lcd_cfg.enable_phase_ms    = RST_ENABLE_PHASE;
        lcd_cfg.use_busy_poll      = RST_USE_BUSY_POLL;
        lcd_cfg.fixed_wait_ms      = RST_FIXED_WAIT;
        lcd_now    = '0;
        lcd_now.ph = PH_UNINIT;
        lcd_plan   = lcd_now;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Early commands and data are refused and ticks do nothing, then a full start-up runs on the reset settings.
        queue_req(make_req(OP_TICK, 8'h00, 1'b0));
        queue_req(make_req(OP_CMD, 8'h00, 1'b1));
        queue_req(make_req(OP_DATA, 8'hFF, 1'b0));
        queue_req(make_req(OP_TICK, 8'hFF, 1'b1));
        queue_req(make_req(OP_INIT, 8'h00, 1'b0));
        queue_req(make_req(OP_INIT, 8'hFF, 1'b1));
        queue_req(make_req(OP_CMD, 8'hA5, 1'b0));
        queue_req(make_req(OP_DATA, 8'h5A, 1'b1));
        queue_until_ready();
        queue_req(make_req(OP_TICK, 8'h3C, 1'b1));
        queue_req(make_req(OP_CMD, 8'hFF, 1'b1));
        queue_until_ready();
        queue_req(make_req(OP_DATA, 8'h00, 1'b0));
        queue_until_ready();
        queue_req(make_req(OP_DATA, 8'hFF, 1'b1));
        queue_until_ready();
        queue_req(make_req(OP_INIT, 8'h81, 1'b0));
        queue_req(make_req(OP_INIT, 8'h00, 1'b0));

        run_setting(8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 120);
        run_setting(8'd2, 8'd1, 8'd1, 8'd0, 8'd0, 120);
        run_setting(8'd255, 8'd255, 8'd15, 8'd0, 8'd255, 160);
        run_setting(8'd3, 8'd2, 8'd15, 8'd1, 8'd1, 120);
        wait_drain();
        cfg_write(CFG_IDX_SPARE, 8'hFF);
        run_setting(8'd1, 8'd1, 8'd1, 8'd1, 8'd1, 120);

        wait_drain();
        repeat (4) @(posedge clk);
        if (mismatch_cnt == 0) begin
            $display("char_lcd_4bit_write_controller_core test passed");
        end else begin
            $display("char_lcd_4bit_write_controller_core test failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/clcd4_pkg.sv
hw/rtl/clcd4_cfg.sv
hw/rtl/clcd4_seq.sv
hw/rtl/clcd4_out.sv
hw/rtl/char_lcd_4bit_write_controller_core.sv
tb/sv/tb_top.sv
